@@ design/rti_pkg.sv @@
package rti_pkg;

   localparam int COORD_BITS = 16;
   localparam int EW         = COORD_BITS + 1;       // edges, offsets, direction
   localparam int PW         = 2 * EW + 1;           // cross product terms
   localparam int XW         = EW + PW;              // dot product terms
   localparam int NW         = XW + 2;               // determinant and numerators
   localparam int ENL_BITS   = 17;
   localparam int DMIN_BITS  = 32;
   localparam int KW         = ENL_BITS + 1;
   localparam int CW         = NW + KW + 1;          // scaled bound compares
   localparam int FRAC_OUT   = 16;
   localparam int DIST_BITS  = 31;
   localparam int BARY_BITS  = 19;
   localparam int INT_OUT    = DIST_BITS - FRAC_OUT;
   localparam int DIV_LAT    = DIST_BITS + 1;
   localparam int Q_DEPTH    = 16;
   localparam int REQ_BITS   = 9 * COORD_BITS;
   localparam int RSP_BITS   = ((DIST_BITS + 2 * BARY_BITS + 7) / 8) * 8;
   localparam int CSR_BITS   = 1;

   localparam logic [CSR_BITS-1:0] CSR_ENLARGE = 1'b0;
   localparam logic [CSR_BITS-1:0] CSR_DET_MIN = 1'b1;

   localparam logic ACT_LOAD = 1'b0;
   localparam logic ACT_TEST = 1'b1;

   typedef struct packed {
      logic          hit;
      logic          u_neg;
      logic          v_neg;
      logic [NW-1:0] mu;
      logic [NW-1:0] mv;
      logic [NW-1:0] mt;
      logic [NW-1:0] den;
   } entry_type;

endpackage

@@ design/rti_div.sv @@
module rti_div (
   input  logic                        clock,
   input  logic                        en,
   input  logic [rti_pkg::NW-1:0]      num,
   input  logic [rti_pkg::NW-1:0]      den,
   output logic [rti_pkg::DIST_BITS-1:0] quo
);

   localparam int NW = rti_pkg::NW;
   localparam int QB = rti_pkg::DIST_BITS;
   localparam int QI = rti_pkg::INT_OUT;
   localparam int LAT = rti_pkg::DIV_LAT;

   // Restoring division, one quotient bit per stage. The word w holds the
   // dividend bits still to come in its top and the quotient bits so far below.
   logic [NW-1:0] rem_ff [LAT];
   logic [NW-1:0] den_ff [LAT];
   logic [QB-1:0] w_ff   [LAT];
   logic          sat_ff [LAT];

   logic [NW:0]   trial [LAT];
   logic          ge    [LAT];

   always_comb begin
      trial[0] = '0;
      ge[0]    = 1'b0;
      for (int s = 1; s < LAT; s++) begin
         trial[s] = {rem_ff[s-1], w_ff[s-1][QB-1]};
         ge[s]    = trial[s] >= {1'b0, den_ff[s-1]};
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         sat_ff[0] <= {{QI{1'b0}}, num} >= {den, {QI{1'b0}}};
         rem_ff[0] <= num >> QI;
         w_ff[0]   <= {num[QI-1:0], {rti_pkg::FRAC_OUT{1'b0}}};
         den_ff[0] <= den;
         for (int s = 1; s < LAT; s++) begin
            rem_ff[s] <= ge[s] ? NW'(trial[s] - {1'b0, den_ff[s-1]}) : trial[s][NW-1:0];
            w_ff[s]   <= {w_ff[s-1][QB-2:0], ge[s]};
            den_ff[s] <= den_ff[s-1];
            sat_ff[s] <= sat_ff[s-1];
         end
      end
   end

   assign quo = sat_ff[LAT-1] ? {QB{1'b1}} : w_ff[LAT-1];

endmodule

@@ design/rti_fifo.sv @@
module rti_fifo (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   input  rti_pkg::entry_type  push_data,
   input  logic                pop,
   output logic                empty,
   output rti_pkg::entry_type  head
);

   localparam int AW = $clog2(rti_pkg::Q_DEPTH);

   rti_pkg::entry_type slot_ff [rti_pkg::Q_DEPTH];
   logic [AW-1:0] wr_ff, wr_in, rd_ff, rd_in;
   logic [AW:0]   cnt_ff, cnt_in;

   always_comb begin
      wr_in  = push ? wr_ff + 1'b1 : wr_ff;
      rd_in  = pop ? rd_ff + 1'b1 : rd_ff;
      cnt_in = cnt_ff + (AW+1)'(push) - (AW+1)'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ff] <= push_data;
      end
   end

   assign empty = (cnt_ff == '0);
   assign head  = slot_ff[rd_ff];

endmodule

@@ design/rti_front.sv @@
module rti_front (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_tvalid,
   output logic                           req_tready,
   input  logic [rti_pkg::REQ_BITS-1:0]   req_tdata,
   input  logic                           req_tuser,
   input  logic                           csr_valid,
   output logic                           csr_ready,
   input  logic [rti_pkg::CSR_BITS-1:0]   csr_index,
   input  logic [rti_pkg::DMIN_BITS-1:0]  csr_data,
   input  logic                           pop,
   output logic                           push,
   output rti_pkg::entry_type             push_data
);

   localparam int CB = rti_pkg::COORD_BITS;
   localparam int EW = rti_pkg::EW;
   localparam int PW = rti_pkg::PW;
   localparam int XW = rti_pkg::XW;
   localparam int NW = rti_pkg::NW;
   localparam int CW = rti_pkg::CW;
   localparam int KW = rti_pkg::KW;
   localparam int FO = rti_pkg::FRAC_OUT;
   localparam int QC = $clog2(rti_pkg::Q_DEPTH + 1);

   typedef logic signed [CB-1:0] crd_type;
   typedef logic signed [EW-1:0] ev_type;
   typedef logic signed [2*EW-1:0] pr_type;
   typedef logic signed [PW-1:0] cr_type;
   typedef logic signed [XW-1:0] dt_type;
   typedef logic signed [NW-1:0] nw_type;
   typedef logic signed [NW:0] sw_type;

   logic [rti_pkg::ENL_BITS-1:0]  enl_ff;
   logic [rti_pkg::DMIN_BITS-1:0] dmin_ff;
   crd_type org_ff [3];
   crd_type dir_ff [3];
   logic [QC-1:0] credit_ff, credit_in;

   crd_type a_c [3], b_c [3], c_c [3];
   ev_type  e1_c [3], e2_c [3], tv_c [3];
   logic    accept, take_test;

   // stage registers
   logic    v1_ff, v2_ff, v3_ff, v4_ff, v5_ff, v6_ff, v7_ff, v8_ff;
   ev_type  e1_1 [3], e2_1 [3], tv_1 [3], dr_1 [3];
   ev_type  e1_2 [3], e2_2 [3], tv_2 [3], dr_2 [3];
   pr_type  pa_2 [3], pb_2 [3], qa_2 [3], qb_2 [3];
   ev_type  e1_3 [3], e2_3 [3], tv_3 [3], dr_3 [3];
   cr_type  p_3 [3], q_3 [3];
   dt_type  xd_4 [3], xu_4 [3], xv_4 [3], xt_4 [3];
   nw_type  det_5, un_5, vn_5, tn_5;

   logic          un_neg_6, un_pos_6, vn_neg_6, s_pos_6, tn_neg_6, det_ok_6, hneg_6;
   logic [NW-1:0] d_6, mu_6, mv_6, mt_6;
   logic [NW:0]   ms_6;

   logic          un_neg_7, un_pos_7, vn_neg_7, s_pos_7, tn_neg_7, det_ok_7;
   logic [NW-1:0] d_7, mu_7, mv_7, mt_7;
   logic [NW:0]   ms_7;
   logic [CW-1:0] klo_7, khi_7;

   rti_pkg::entry_type ent_8;

   nw_type        un_f, vn_f, tn_f, det_f;
   sw_type        s_f;
   logic [KW-1:0] k_lo, k_hi;
   logic          miss_c;

   assign csr_ready  = 1'b1;
   assign req_tready = credit_ff < QC'(rti_pkg::Q_DEPTH);
   assign accept     = req_tvalid && req_tready;
   assign take_test  = accept && (req_tuser == rti_pkg::ACT_TEST);

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         a_c[i]  = crd_type'(req_tdata[i*CB +: CB]);
         b_c[i]  = crd_type'(req_tdata[(3+i)*CB +: CB]);
         c_c[i]  = crd_type'(req_tdata[(6+i)*CB +: CB]);
         e1_c[i] = ev_type'(b_c[i]) - ev_type'(a_c[i]);
         e2_c[i] = ev_type'(c_c[i]) - ev_type'(a_c[i]);
         tv_c[i] = ev_type'(org_ff[i]) - ev_type'(a_c[i]);
      end
      credit_in = credit_ff + QC'(take_test) - QC'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         enl_ff    <= '0;
         dmin_ff   <= rti_pkg::DMIN_BITS'(1);
         credit_ff <= '0;
         v1_ff <= 1'b0; v2_ff <= 1'b0; v3_ff <= 1'b0; v4_ff <= 1'b0;
         v5_ff <= 1'b0; v6_ff <= 1'b0; v7_ff <= 1'b0; v8_ff <= 1'b0;
         for (int i = 0; i < 3; i++) begin
            org_ff[i] <= '0;
            dir_ff[i] <= '0;
         end
      end else begin
         if (csr_valid) begin
            unique case (csr_index)
               rti_pkg::CSR_ENLARGE: enl_ff  <= csr_data[rti_pkg::ENL_BITS-1:0];
               rti_pkg::CSR_DET_MIN: dmin_ff <= csr_data;
            endcase
         end
         if (accept && req_tuser == rti_pkg::ACT_LOAD) begin
            for (int i = 0; i < 3; i++) begin
               org_ff[i] <= a_c[i];
               dir_ff[i] <= b_c[i];
            end
         end
         credit_ff <= credit_in;
         v1_ff <= take_test;
         v2_ff <= v1_ff; v3_ff <= v2_ff; v4_ff <= v3_ff; v5_ff <= v4_ff;
         v6_ff <= v5_ff; v7_ff <= v6_ff; v8_ff <= v7_ff;
      end
   end

   // Sign fix so that the determinant reads as positive from here on.
   always_comb begin
      hneg_6 = det_5[NW-1];
      det_f  = hneg_6 ? -det_5 : det_5;
      un_f   = hneg_6 ? -un_5 : un_5;
      vn_f   = hneg_6 ? -vn_5 : vn_5;
      tn_f   = hneg_6 ? -tn_5 : tn_5;
      s_f    = sw_type'(un_f) + sw_type'(vn_f);
      k_lo   = {1'b0, enl_ff};
      k_hi   = KW'(1 << FO) + {1'b0, enl_ff};
   end

   always_comb begin
      miss_c = !det_ok_7 || tn_neg_7;
      if (un_neg_7 && ({{(CW-NW-FO){1'b0}}, mu_7, {FO{1'b0}}} > klo_7)) miss_c = 1'b1;
      if (un_pos_7 && ({{(CW-NW-FO){1'b0}}, mu_7, {FO{1'b0}}} > khi_7)) miss_c = 1'b1;
      if (vn_neg_7 && ({{(CW-NW-FO){1'b0}}, mv_7, {FO{1'b0}}} > klo_7)) miss_c = 1'b1;
      if (s_pos_7 && ({{(CW-NW-FO-1){1'b0}}, ms_7, {FO{1'b0}}} > khi_7)) miss_c = 1'b1;
   end

   always_ff @(posedge clock) begin
      // stage 1: edges and origin offset
      for (int i = 0; i < 3; i++) begin
         e1_1[i] <= e1_c[i];
         e2_1[i] <= e2_c[i];
         tv_1[i] <= tv_c[i];
         dr_1[i] <= ev_type'(dir_ff[i]);
      end
      // stage 2: cross product partial products
      for (int i = 0; i < 3; i++) begin
         pa_2[i] <= dr_1[(i+1)%3] * e2_1[(i+2)%3];
         pb_2[i] <= dr_1[(i+2)%3] * e2_1[(i+1)%3];
         qa_2[i] <= tv_1[(i+1)%3] * e1_1[(i+2)%3];
         qb_2[i] <= tv_1[(i+2)%3] * e1_1[(i+1)%3];
         e1_2[i] <= e1_1[i]; e2_2[i] <= e2_1[i]; tv_2[i] <= tv_1[i]; dr_2[i] <= dr_1[i];
      end
      // stage 3: cross products
      for (int i = 0; i < 3; i++) begin
         p_3[i]  <= cr_type'(pa_2[i]) - cr_type'(pb_2[i]);
         q_3[i]  <= cr_type'(qa_2[i]) - cr_type'(qb_2[i]);
         e1_3[i] <= e1_2[i]; e2_3[i] <= e2_2[i]; tv_3[i] <= tv_2[i]; dr_3[i] <= dr_2[i];
      end
      // stage 4: dot product terms
      for (int i = 0; i < 3; i++) begin
         xd_4[i] <= e1_3[i] * p_3[i];
         xu_4[i] <= tv_3[i] * p_3[i];
         xv_4[i] <= dr_3[i] * q_3[i];
         xt_4[i] <= e2_3[i] * q_3[i];
      end
      // stage 5: sums
      det_5 <= nw_type'(xd_4[0]) + nw_type'(xd_4[1]) + nw_type'(xd_4[2]);
      un_5  <= nw_type'(xu_4[0]) + nw_type'(xu_4[1]) + nw_type'(xu_4[2]);
      vn_5  <= nw_type'(xv_4[0]) + nw_type'(xv_4[1]) + nw_type'(xv_4[2]);
      tn_5  <= nw_type'(xt_4[0]) + nw_type'(xt_4[1]) + nw_type'(xt_4[2]);
      // stage 6: magnitudes and signs
      d_6      <= det_f;
      det_ok_6 <= (det_5 != '0) && (det_f >= NW'(dmin_ff));
      un_neg_6 <= un_f[NW-1];
      un_pos_6 <= !un_f[NW-1] && (un_f != '0);
      vn_neg_6 <= vn_f[NW-1];
      tn_neg_6 <= tn_f[NW-1];
      s_pos_6  <= !s_f[NW] && (s_f != '0);
      mu_6     <= un_f[NW-1] ? NW'(-un_f) : un_f;
      mv_6     <= vn_f[NW-1] ? NW'(-vn_f) : vn_f;
      mt_6     <= tn_f;
      ms_6     <= s_f;
      // stage 7: bound products
      klo_7    <= CW'(k_lo) * CW'(d_6);
      khi_7    <= CW'(k_hi) * CW'(d_6);
      d_7 <= d_6; det_ok_7 <= det_ok_6; un_neg_7 <= un_neg_6; un_pos_7 <= un_pos_6;
      vn_neg_7 <= vn_neg_6; tn_neg_7 <= tn_neg_6; s_pos_7 <= s_pos_6;
      mu_7 <= mu_6; mv_7 <= mv_6; mt_7 <= mt_6; ms_7 <= ms_6;
      // stage 8: decision
      ent_8.hit   <= !miss_c;
      ent_8.u_neg <= un_neg_7;
      ent_8.v_neg <= vn_neg_7;
      ent_8.mu    <= mu_7;
      ent_8.mv    <= mv_7;
      ent_8.mt    <= mt_7;
      ent_8.den   <= d_7;
   end

   assign push      = v8_ff;
   assign push_data = ent_8;

endmodule

@@ design/rti_back.sv @@
module rti_back (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          empty,
   input  rti_pkg::entry_type            head,
   output logic                          pop,
   output logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   output logic [rti_pkg::RSP_BITS-1:0]  rsp_tdata,
   output logic                          rsp_tuser
);

   localparam int LAT = rti_pkg::DIV_LAT;
   localparam int QB  = rti_pkg::DIST_BITS;
   localparam int BB  = rti_pkg::BARY_BITS;

   logic en;
   logic vld_ff [LAT];
   logic hit_ff [LAT];
   logic un_ff  [LAT];
   logic vn_ff  [LAT];
   logic [QB-1:0] qu, qv, qt;
   logic [BB-1:0] bu_c, bv_c;

   logic          out_v_ff, out_hit_ff;
   logic [QB-1:0] out_t_ff;
   logic [BB-1:0] out_u_ff, out_v_ff_d;

   assign en  = !out_v_ff || rsp_tready;
   assign pop = en && !empty;

   rti_div u_div_u (.clock(clock), .en(en), .num(head.mu), .den(head.den), .quo(qu));
   rti_div u_div_v (.clock(clock), .en(en), .num(head.mv), .den(head.den), .quo(qv));
   rti_div u_div_t (.clock(clock), .en(en), .num(head.mt), .den(head.den), .quo(qt));

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int s = 0; s < LAT; s++) vld_ff[s] <= 1'b0;
         out_v_ff <= 1'b0;
      end else if (en) begin
         vld_ff[0] <= !empty;
         for (int s = 1; s < LAT; s++) vld_ff[s] <= vld_ff[s-1];
         out_v_ff <= vld_ff[LAT-1];
      end
   end

   always_comb begin
      bu_c = un_ff[LAT-1] ? BB'(0) - qu[BB-1:0] : qu[BB-1:0];
      bv_c = vn_ff[LAT-1] ? BB'(0) - qv[BB-1:0] : qv[BB-1:0];
   end

   always_ff @(posedge clock) begin
      if (en) begin
         hit_ff[0] <= head.hit;
         un_ff[0]  <= head.u_neg;
         vn_ff[0]  <= head.v_neg;
         for (int s = 1; s < LAT; s++) begin
            hit_ff[s] <= hit_ff[s-1];
            un_ff[s]  <= un_ff[s-1];
            vn_ff[s]  <= vn_ff[s-1];
         end
         out_hit_ff <= hit_ff[LAT-1];
         out_t_ff   <= hit_ff[LAT-1] ? qt : '0;
         out_u_ff   <= hit_ff[LAT-1] ? bu_c : '0;
         out_v_ff_d <= hit_ff[LAT-1] ? bv_c : '0;
      end
   end

   assign rsp_tvalid = out_v_ff;
   assign rsp_tuser  = out_hit_ff;
   assign rsp_tdata  = {{(rti_pkg::RSP_BITS - QB - 2*BB){1'b0}}, out_v_ff_d, out_u_ff, out_t_ff};

endmodule

@@ design/ray_triangle_intersection_core.sv @@
// Channel | Ports  | Contents
// request | req_*  | tuser: action; tdata: a_x a_y a_z b_x b_y b_z c_x c_y c_z
// result  | rsp_*  | tuser: hit; tdata: distance bary_u bary_v
// csr     | csr_*  | index 0 enlarge, index 1 det_min
// One item is accepted per cycle while req_tready is high. A test item passes
// through 8 stages of exact geometry, one queue write, 32 divider stages (a
// saturation check, then one quotient bit per stage) and one output stage.
// A 16-entry queue between geometry and division sets the credit that gates
// req_tready; a stalled result stalls the divider pipeline only.
// Reset is synchronous; it clears the ray, the enlarge register and all valids, and sets det_min to 1.
module ray_triangle_intersection_core (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_tvalid,
   output logic                          req_tready,
   input  logic [rti_pkg::REQ_BITS-1:0]  req_tdata,  // a_x,a_y,a_z,b_x,b_y,b_z,c_x,c_y,c_z
   input  logic                          req_tuser,  // action
   output logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   output logic [rti_pkg::RSP_BITS-1:0]  rsp_tdata,  // distance, bary_u, bary_v, zero pad
   output logic                          rsp_tuser,  // hit
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [rti_pkg::CSR_BITS-1:0]  csr_index,
   input  logic [rti_pkg::DMIN_BITS-1:0] csr_data
);

   logic               push, pop, empty;
   rti_pkg::entry_type push_data, head;

   rti_front u_front (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_tdata(req_tdata), .req_tuser(req_tuser),
      .csr_valid(csr_valid), .csr_ready(csr_ready),
      .csr_index(csr_index), .csr_data(csr_data),
      .pop(pop), .push(push), .push_data(push_data)
   );

   rti_fifo u_fifo (
      .clock(clock), .reset(reset),
      .push(push), .push_data(push_data),
      .pop(pop), .empty(empty), .head(head)
   );

   rti_back u_back (
      .clock(clock), .reset(reset),
      .empty(empty), .head(head), .pop(pop),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata), .rsp_tuser(rsp_tuser)
   );

endmodule

@@ sim/rti_checker.sv @@
module rti_checker (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_tvalid,
   input  logic                          req_tready,
   input  logic [rti_pkg::REQ_BITS-1:0]  req_tdata,
   input  logic                          req_tuser,
   input  logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   input  logic [rti_pkg::RSP_BITS-1:0]  rsp_tdata,
   input  logic                          rsp_tuser,
   input  logic                          csr_valid,
   input  logic                          csr_ready,
   input  logic [rti_pkg::CSR_BITS-1:0]  csr_index,
   input  logic [rti_pkg::DMIN_BITS-1:0] csr_data,
   output int                            fail_count,
   output int                            hits_pending
);
   timeunit 1ns;
   timeprecision 1ps;
   import rti_pkg::*;

   typedef struct packed {
      logic        hit;
      logic [30:0] distance;
      logic [18:0] bary_u;
      logic [18:0] bary_v;
   } hit_result_t;

   hit_result_t           expected_hits[$];
   logic [16:0]           enlarge_q16;
   logic [31:0]           det_floor;
   logic signed [63:0]    ray_org[3];
   logic signed [63:0]    ray_dir[3];

   // True when m * 2^16 exceeds k * d, evaluated exactly.
   function automatic bit exceeds_bound(logic [127:0] m, logic [127:0] k, logic [127:0] d);
      return (m << 16) > (k * d);
   endfunction

   // Q25.16 quotient, truncated, with integer part capped at 2^24.
   function automatic logic [63:0] q16_quotient(logic [127:0] m, logic [127:0] d);
      logic [127:0] ip;
      logic [127:0] fp;
      ip = m / d;
      fp = ((m % d) << 16) / d;
      if (ip > (128'd1 << 24))
         ip = 128'd1 << 24;
      return 64'((ip << 16) | fp);
   endfunction

   function automatic hit_result_t predict(logic [REQ_BITS-1:0] verts);
      logic signed [127:0] a[3], b[3], c[3], e1[3], e2[3], tv[3], p[3], q[3];
      logic signed [127:0] det, un, vn, tn, mu, mv, d, k1;
      logic [63:0]         qu, qv, qt;
      hit_result_t         r;
      r = '0;
      for (int i = 0; i < 3; i++) begin
         a[i] = 128'(signed'(verts[16*i +: 16]));
         b[i] = 128'(signed'(verts[16*(i+3) +: 16]));
         c[i] = 128'(signed'(verts[16*(i+6) +: 16]));
      end
      for (int i = 0; i < 3; i++) begin
         e1[i] = b[i] - a[i];
         e2[i] = c[i] - a[i];
         tv[i] = 128'(ray_org[i]) - a[i];
      end
      for (int i = 0; i < 3; i++) begin
         p[i] = 128'(ray_dir[(i+1)%3]) * e2[(i+2)%3] - 128'(ray_dir[(i+2)%3]) * e2[(i+1)%3];
         q[i] = tv[(i+1)%3] * e1[(i+2)%3] - tv[(i+2)%3] * e1[(i+1)%3];
      end
      det = e1[0]*p[0] + e1[1]*p[1] + e1[2]*p[2];
      un  = tv[0]*p[0] + tv[1]*p[1] + tv[2]*p[2];
      vn  = 128'(ray_dir[0])*q[0] + 128'(ray_dir[1])*q[1] + 128'(ray_dir[2])*q[2];
      tn  = e2[0]*q[0] + e2[1]*q[1] + e2[2]*q[2];
      if (det < 0) begin
         un = -un;
         vn = -vn;
         tn = -tn;
      end
      d  = det < 0 ? -det : det;
      mu = un < 0 ? -un : un;
      mv = vn < 0 ? -vn : vn;
      k1 = 128'd65536 + enlarge_q16;
      if (d == 0 || d < det_floor) return r;
      if (un < 0 && exceeds_bound(mu, enlarge_q16, d)) return r;
      if (un > 0 && exceeds_bound(mu, k1, d)) return r;
      if (vn < 0 && exceeds_bound(mv, enlarge_q16, d)) return r;
      if (un + vn > 0 && exceeds_bound(un + vn, k1, d)) return r;
      if (tn < 0) return r;
      qu = q16_quotient(mu, d);
      qv = q16_quotient(mv, d);
      qt = q16_quotient(tn, d);
      if (qt > 64'h7FFF_FFFF)
         qt = 64'h7FFF_FFFF;
      r.hit      = 1'b1;
      r.distance = qt[30:0];
      r.bary_u   = un < 0 ? 19'(-qu) : qu[18:0];
      r.bary_v   = vn < 0 ? 19'(-qv) : qv[18:0];
      return r;
   endfunction

   always @(posedge clock) begin
      hit_result_t got;
      hit_result_t want;
      if (reset) begin
         enlarge_q16 <= 17'd0;
         det_floor   <= 32'd1;
         for (int i = 0; i < 3; i++) begin
            ray_org[i] = 64'sd0;
            ray_dir[i] = 64'sd0;
         end
         expected_hits.delete();
         fail_count <= 0;
      end else begin
         if (csr_valid && csr_ready) begin
            if (csr_index == CSR_ENLARGE)
               enlarge_q16 <= csr_data[16:0];
            else
               det_floor <= csr_data;
         end
         if (req_tvalid && req_tready) begin
            if (req_tuser == ACT_LOAD) begin
               for (int i = 0; i < 3; i++) begin
                  ray_org[i] = 64'(signed'(req_tdata[16*i +: 16]));
                  ray_dir[i] = 64'(signed'(req_tdata[16*(i+3) +: 16]));
               end
            end else begin
               expected_hits.push_back(predict(req_tdata));
            end
         end
         if (rsp_tvalid && rsp_tready) begin
            got = {rsp_tuser, rsp_tdata[30:0], rsp_tdata[49:31], rsp_tdata[68:50]};
            if (expected_hits.size() == 0) begin
               $display("%0t: unexpected result, actual %h", $time, got);
               fail_count <= fail_count + 1;
            end else begin
               want = expected_hits.pop_front();
               if (got.hit !== want.hit || got.distance !== want.distance ||
                   got.bary_u !== want.bary_u || got.bary_v !== want.bary_v) begin
                  $display("%0t: mismatch hit/t/u/v expected %b %h %h %h actual %b %h %h %h",
                           $time, want.hit, want.distance, want.bary_u, want.bary_v,
                           got.hit, got.distance, got.bary_u, got.bary_v);
                  fail_count <= fail_count + 1;
               end
            end
         end
      end
      hits_pending = expected_hits.size();
   end
endmodule

@@ sim/tb_ray_triangle_intersection_core.sv @@
module tb_ray_triangle_intersection_core;
   timeunit 1ns;
   timeprecision 1ps;
   import rti_pkg::*;

   localparam int WATCHDOG_LIMIT = 20000;
   localparam int DRAIN_CYCLES   = 60;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_BITS-1:0]   req_tdata = '0;
   logic                  req_tuser = ACT_LOAD;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_BITS-1:0]   rsp_tdata;
   logic                  rsp_tuser;
   logic                  csr_valid = 1'b0;
   logic                  csr_ready;
   logic [CSR_BITS-1:0]   csr_index = CSR_ENLARGE;
   logic [DMIN_BITS-1:0]  csr_data = '0;
   int                    fail_count;
   int                    hits_pending;
   int                    send_idle_pct = 0;
   int                    stall_pct = 0;
   int                    hold_off_cycles = 0;
   int                    quiet_cycles = 0;

   ray_triangle_intersection_core i_dut (.*);

   rti_checker i_checker (.*);

   initial begin
      forever #6 clock = ~clock;
   end

   // Result side backpressure, with an optional long hold-off.
   always @(posedge clock) begin
      if (hold_off_cycles > 0) begin
         hold_off_cycles <= hold_off_cycles - 1;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(99) >= stall_pct);
      end
   end

   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) || (csr_valid && csr_ready))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles > WATCHDOG_LIMIT) begin
         $display("tb_ray_triangle_intersection_core: FAIL");
         $finish;
      end
   end

   task automatic write_reg(logic [CSR_BITS-1:0] idx, logic [31:0] value);
      csr_index <= idx;
      csr_data  <= value;
      csr_valid <= 1'b1;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   task automatic send_item(logic act, logic [REQ_BITS-1:0] coords);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tuser  <= act;
      req_tdata  <= coords;
      req_tvalid <= 1'b1;
      do @(posedge clock); while (!req_tready);
   endtask

   task automatic end_burst();
      req_tvalid <= 1'b0;
      @(posedge clock);
   endtask

   task automatic wait_drained();
      while (hits_pending != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   function automatic logic [15:0] coord(logic [15:0] small_range);
      case ($urandom_range(9))
         0:       return 16'h7FFF;
         1:       return 16'h8000;
         2:       return 16'($urandom);
         default: return 16'($signed(16'($urandom_range(2 * small_range))) - $signed(small_range));
      endcase
   endfunction

   // A ray aimed near the triangle so that many tests land inside it.
   task automatic send_aimed_set(int tests);
      logic [15:0] o[3], dr[3], v[9];
      for (int i = 0; i < 3; i++) begin
         o[i]  = coord(16'd1024);
         dr[i] = coord(16'd512);
      end
      send_item(ACT_LOAD, {48'($urandom), dr[2], dr[1], dr[0], o[2], o[1], o[0]});
      for (int n = 0; n < tests; n++) begin
         for (int i = 0; i < 3; i++) begin
            for (int j = 0; j < 3; j++)
               v[3*j+i] = o[i] + dr[i] * 16'($urandom_range(3)) + coord(16'd768);
         end
         send_item(ACT_TEST, {v[8], v[7], v[6], v[5], v[4], v[3], v[2], v[1], v[0]});
      end
   endtask

   task automatic random_phase(int items, int idle, int stall);
      send_idle_pct = idle;
      stall_pct     = stall;
      while (items > 0) begin
         if ($urandom_range(9) == 0) begin
            send_item(1'($urandom_range(1)),
                      REQ_BITS'({$urandom, $urandom, $urandom, $urandom, $urandom}));
            items--;
         end else begin
            send_aimed_set(8);
            items -= 9;
         end
      end
      end_burst();
   endtask

   initial begin
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Test before any load, then axis-aligned and extreme cases.
      send_item(ACT_TEST, {16'd0, 16'd256, 16'd0, 16'd256, 16'd0, 16'd0, 48'd0});
      send_item(ACT_LOAD, {48'd0, 16'd256, 16'd0, 16'd0, 16'h0040, 16'h0040, 16'hFF00});
      send_item(ACT_TEST, {16'd0, 16'd0, 16'd256, 16'd0, 16'd256, 16'd0, 48'd0});
      send_item(ACT_TEST, {16'd0, 16'd256, 16'd0, 16'd0, 16'd0, 16'd256, 48'd0});
      send_item(ACT_TEST, {16'd0, 16'd0, 16'd256, 16'd0, 16'd256, 16'd0, 16'd0, 16'd0, 16'd0});
      send_item(ACT_TEST, {16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 48'd0});
      send_item(ACT_TEST, {16'd0, 16'd0, 16'd256, 16'd0, 16'd256, 16'd0, 16'd0, 16'd0,
                           16'hFF00});
      send_item(ACT_TEST, {9{16'h7FFF}});
      send_item(ACT_TEST, {9{16'h8000}});
      send_item(ACT_TEST, {16'h7FFF, 16'h8000, 16'h7FFF, 16'h8000, 16'h7FFF, 16'h8000,
                           16'h7FFF, 16'h8000, 16'h7FFF});
      send_item(ACT_LOAD, {48'hFFFF_FFFF_FFFF, 16'h0001, 16'h0000, 16'h0000, 48'd0});
      send_item(ACT_TEST, {16'h0100, 16'h7FFF, 16'h8000, 16'h0100, 16'h8000, 16'h8000,
                           16'h0100, 16'h8000, 16'h7FFF});
      send_item(ACT_LOAD, {16'h8000, 16'h7FFF, 16'h8000, 16'h7FFF, 16'h8000, 16'h7FFF, 48'd0});
      send_item(ACT_TEST, {16'h0000, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h0000, 16'h8000,
                           16'h8000, 16'h8000, 16'h0000});
      end_burst();
      wait_drained();

      write_reg(CSR_ENLARGE, 32'd65536);
      write_reg(CSR_DET_MIN, 32'd0);
      random_phase(400, 0, 0);
      wait_drained();

      write_reg(CSR_ENLARGE, 32'h1FFFF);
      write_reg(CSR_DET_MIN, 32'hFFFF_FFFF);
      random_phase(100, 72, 0);
      wait_drained();

      write_reg(CSR_ENLARGE, 32'd0);
      write_reg(CSR_DET_MIN, 32'd1);
      random_phase(500, 0, 72);
      wait_drained();

      // Long hold-off on results while items keep coming, to fill the queue.
      hold_off_cycles <= 300;
      random_phase(120, 0, 0);
      wait_drained();

      write_reg(CSR_ENLARGE, 32'd3277);
      write_reg(CSR_DET_MIN, 32'd65536);
      random_phase(500, 34, 34);
      wait_drained();

      write_reg(CSR_ENLARGE, $urandom_range(65536));
      write_reg(CSR_DET_MIN, $urandom_range(4096));
      random_phase(400, 0, 0);
      wait_drained();

      if (fail_count == 0)
         $display("tb_ray_triangle_intersection_core: PASS");
      else
         $display("tb_ray_triangle_intersection_core: FAIL");
      $finish;
   end
endmodule
